>>> design/pgwalk_pkg.sv
// pgwalk_pkg: shared types and codes for the four-level page table walker.
// Holds the input and result word structs, table entry layout and the
// sequencer state type. No dependencies.
package pgwalk_pkg;

  localparam int VA_W   = 48;
  localparam int PAGE_W = 40;
  localparam int OFF_W  = 12;
  localparam int IDX_W  = 9;
  localparam int ENTRY_W = PAGE_W + 2;

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_MAP       = 2'd1;
  localparam logic [1:0] ACT_UNMAP     = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ABSENT = 3'd1;
  localparam logic [2:0] ST_RANGE  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_KEPT   = 3'd4;

  localparam logic [PAGE_W-1:0] BASE_RESET = 40'd256;

  typedef struct packed {
    logic [1:0]        action;
    logic [VA_W-1:0]   virtual_address;
    logic [PAGE_W-1:0] target_page;
    logic              overwrite;
  } pgwalk_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic [OFF_W-1:0]  page_offset;
    logic [2:0]        status;
  } pgwalk_out_t;

  typedef struct packed {
    logic              writable;
    logic              present;
    logic [PAGE_W-1:0] page;
  } pgwalk_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EVAL,
    S_DONE
  } pgwalk_state_t;

endpackage

>>> design/pgwalk_store.sv
// pgwalk_store: single-port page table store, one access per cycle.
// Read data is registered. Uses pgwalk_pkg for the entry layout.
module pgwalk_store
  import pgwalk_pkg::*;
#(
  parameter int ADDR_W = 15,
  parameter int DEPTH  = 32768
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  pgwalk_entry_t     wdata,
  output pgwalk_entry_t     rdata
);

  pgwalk_entry_t mem [DEPTH];
  pgwalk_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/four_level_page_table_walker_unit.sv
// four_level_page_table_walker_unit: top level of the page table walker.
// Sequencer, range check and entry update logic; store in pgwalk_store.
// Depends on pgwalk_pkg.
//
//   channel | ports                      | direction | word
//   input   | in_valid in_stall in_data  | in        | pgwalk_in_t
//   result  | out_valid out_stall out_data | out     | pgwalk_out_t
//   config  | cfg_we cfg_wdata           | in        | table_base_page
//
// Each level goes through the single store port in S_ADDR (address check
// and read), then S_EVAL (update/write); a walk repeats these per level,
// then S_DONE; faults end early, and action 3 goes straight to S_DONE.
// After reset all TABLE_PAGES*512 store entries (32768 by default) are
// cleared, with in_stall high. in_stall is high while a word is in work;
// a finished result waits in the output register while out_stall is high.
module four_level_page_table_walker_unit
  import pgwalk_pkg::*;
#(
  parameter int TABLE_PAGES = 64,
  parameter int LEVELS      = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pgwalk_in_t        in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pgwalk_out_t       out_data,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(TABLE_PAGES);
  localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
  localparam int LVL_W  = (LEVELS > 2) ? $clog2(LEVELS) : 1;

  pgwalk_state_t     state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [PAGE_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  next_free_r, next_free_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [VA_W-1:0]   va_r, va_nxt;
  logic [PAGE_W-1:0] target_r, target_nxt;
  logic              ow_r, ow_nxt;
  logic [PAGE_W-1:0] res_r, res_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  pgwalk_out_t       out_data_r, out_data_nxt;

  logic              in_acc;
  logic              out_free;
  logic              clr_last;

  logic [PAGE_W:0]   diff;
  logic              range_ok;
  logic [63:0]       va_pad;
  logic [5:0]        sh;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] chk_addr;

  pgwalk_entry_t     e;
  logic              leaf;
  logic              full;
  logic [PAGE_W-1:0] alloc_page;
  logic [PAGE_W-1:0] leaf_page;
  pgwalk_entry_t     ev_wdata;
  logic              ev_we;
  logic              ev_done;
  logic              ev_alloc;
  logic [PAGE_W-1:0] ev_page;
  logic [PAGE_W-1:0] ev_res;
  logic [2:0]        ev_status;

  logic              mem_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  pgwalk_entry_t     mem_wdata;

  pgwalk_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (e)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_last  = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Address check and entry update for the current level.
  always_comb begin
    diff     = {1'b0, page_r} - {1'b0, base_r};
    range_ok = (page_r != '0) && !diff[PAGE_W] &&
               (diff[PAGE_W-1:0] < PAGE_W'(TABLE_PAGES));
    va_pad   = {{(64 - VA_W){1'b0}}, va_r};
    sh       = 6'(OFF_W + IDX_W * (LEVELS - 1 - int'(lvl_r)));
    idx      = va_pad[sh +: IDX_W];
    chk_addr = {diff[SLOT_W-1:0], idx};

    leaf       = (lvl_r == LVL_W'(LEVELS - 1));
    full       = (next_free_r >= CNT_W'(TABLE_PAGES));
    alloc_page = base_r + PAGE_W'(next_free_r);
    leaf_page  = (!e.present || ow_r) ? target_r : e.page;

    ev_we     = 1'b0;
    ev_wdata  = e;
    ev_done   = 1'b0;
    ev_alloc  = 1'b0;
    ev_page   = e.page;
    ev_res    = '0;
    ev_status = ST_OK;

    if (act_r == ACT_TRANSLATE) begin
      if (!e.present) begin
        ev_done   = 1'b1;
        ev_status = ST_ABSENT;
      end else if (leaf) begin
        ev_done = 1'b1;
        ev_res  = e.page;
      end
    end else if (!leaf) begin
      if (!e.present && full) begin
        ev_done   = 1'b1;
        ev_status = ST_FULL;
      end else begin
        ev_alloc = !e.present;
        ev_page  = e.present ? e.page : alloc_page;
        ev_we    = 1'b1;
        ev_wdata = '{writable: 1'b1, present: 1'b1, page: ev_page};
      end
    end else if (act_r == ACT_MAP) begin
      ev_done   = 1'b1;
      ev_we     = 1'b1;
      ev_wdata  = '{writable: 1'b1, present: 1'b1, page: leaf_page};
      ev_res    = leaf_page;
      ev_status = (leaf_page != target_r) ? ST_KEPT : ST_OK;
    end else begin
      ev_done  = 1'b1;
      ev_we    = 1'b1;
      ev_wdata = '{writable: e.writable, present: 1'b0, page: '0};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.action == ACT_TRANSLATE || in_data.action == ACT_MAP ||
                       in_data.action == ACT_UNMAP) ? S_ADDR : S_DONE;
        end
      end
      S_ADDR:  state_nxt = range_ok ? S_EVAL : S_DONE;
      S_EVAL:  state_nxt = ev_done ? S_DONE : S_ADDR;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    next_free_nxt = next_free_r;
    lvl_nxt       = lvl_r;
    page_nxt      = page_r;
    addr_nxt      = addr_r;
    act_nxt       = act_r;
    va_nxt        = va_r;
    target_nxt    = target_r;
    ow_nxt        = ow_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = addr_r;
    mem_wdata     = ev_wdata;

    unique case (state_r)
      S_CLEAR: begin
        mem_en       = 1'b1;
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt    = in_data.action;
          va_nxt     = in_data.virtual_address;
          target_nxt = in_data.target_page;
          ow_nxt     = in_data.overwrite;
          page_nxt   = base_r;
          lvl_nxt    = '0;
          res_nxt    = '0;
          status_nxt = ST_ABSENT;
        end
      end
      S_ADDR: begin
        if (range_ok) begin
          mem_en   = 1'b1;
          mem_addr = chk_addr;
          addr_nxt = chk_addr;
        end else begin
          res_nxt    = '0;
          status_nxt = ST_RANGE;
        end
      end
      S_EVAL: begin
        mem_en     = ev_we;
        mem_we     = ev_we;
        res_nxt    = ev_res;
        status_nxt = ev_status;
        page_nxt   = ev_page;
        lvl_nxt    = lvl_r + 1'b1;
        if (ev_alloc) next_free_nxt = next_free_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_page = res_r;
          out_data_nxt.page_offset = va_r[OFF_W-1:0];
          out_data_nxt.status      = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      base_r      <= BASE_RESET;
      next_free_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      base_r      <= base_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    page_r     <= page_nxt;
    addr_r     <= addr_nxt;
    act_r      <= act_nxt;
    va_r       <= va_nxt;
    target_r   <= target_nxt;
    ow_r       <= ow_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
